// ===== rtl/core/unix_time_to_calendar_core_macros.svh =====
// assertion helpers used by unix_time_to_calendar_core
`ifndef UNIX_TIME_TO_CALENDAR_CORE_MACROS_SVH
`define UNIX_TIME_TO_CALENDAR_CORE_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define U2CAL_ASSERT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("u2cal assertion failed");
// implication after a fixed number of cycles
`define U2CAL_ASSERT_DLY(label, clk, rst_n, ante, dly, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ## dly (cons)) \
    else $error("u2cal delayed assertion failed");
`else
`define U2CAL_ASSERT(label, clk, rst_n, ante, cons)
`define U2CAL_ASSERT_DLY(label, clk, rst_n, ante, dly, cons)
`endif
`endif

// ===== rtl/core/u2cal_pkg.sv =====
package u2cal_pkg;

  // 2000-01-01 00:00:00 in unix seconds
  localparam logic [31:0] EPOCH_2000 = 32'd946684800;

  localparam int unsigned SEC_PER_MIN   = 60;
  localparam int unsigned SEC_PER_HOUR  = 3600;
  localparam int unsigned SEC_PER_DAY   = 86400;
  localparam int unsigned DAYS_PER_YEAR = 365;
  localparam int unsigned DAYS_LEAP_YR  = DAYS_PER_YEAR + 1;
  localparam int unsigned DAYS_PER_QUAD = 4 * DAYS_PER_YEAR + 1;

  // first day of years one to three inside a four-year block
  localparam int unsigned YEAR1_START = DAYS_LEAP_YR;
  localparam int unsigned YEAR2_START = YEAR1_START + DAYS_PER_YEAR;
  localparam int unsigned YEAR3_START = YEAR2_START + DAYS_PER_YEAR;

  // reciprocals, floor: estimate is exact or one low
  localparam int unsigned DAY_SHIFT  = 48;
  localparam logic [31:0] DAY_RECIP  = 32'((64'd1 << DAY_SHIFT) / 64'(SEC_PER_DAY));
  localparam int unsigned HOUR_SHIFT = 29;
  localparam logic [17:0] HOUR_RECIP = 18'((64'd1 << HOUR_SHIFT) / 64'(SEC_PER_HOUR));
  localparam int unsigned QUAD_SHIFT = 27;
  localparam logic [16:0] QUAD_RECIP = 17'((64'd1 << QUAD_SHIFT) / 64'(DAYS_PER_QUAD));
  // ceiling reciprocal, exact for values below 4096
  localparam int unsigned MIN_SHIFT  = 18;
  localparam logic [12:0] MIN_RECIP  =
    13'(((64'd1 << MIN_SHIFT) + 64'(SEC_PER_MIN) - 64'd1) / 64'(SEC_PER_MIN));

  // accept edge to strobe cycle
  localparam int unsigned PIPE_LATENCY = 10;

  // day of year on which each month starts, common year
  localparam logic [8:0] MONTH_START [12] = '{
    9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
    9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
  };

  typedef struct packed {
    logic        valid;
    logic [15:0] days;
    logic [16:0] sod;
  } day_word_t;

  typedef struct packed {
    logic       valid;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
  } tod_word_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] year;
    logic [3:0] month;
    logic [4:0] day;
  } date_word_t;

  function automatic logic [8:0] month_first_day(input logic [3:0] idx, input logic leap);
    logic [8:0] base;
    base = MONTH_START[idx];
    return base + 9'(leap && (idx >= 4'd2));
  endfunction

endpackage

// ===== rtl/core/u2cal_day_split.sv =====
module u2cal_day_split (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic [31:0]          in_seconds,
  output u2cal_pkg::day_word_t day_o
);
  import u2cal_pkg::*;

  logic [4:1]  v_r;
  logic [31:0] t1_r, t2_r;
  logic [15:0] q2_r, q3_r, days4_r;
  logic [17:0] r3_r;
  logic [16:0] sod4_r;

  logic [31:0] t1_nxt;
  logic [63:0] day_prod;
  logic [15:0] q2_nxt;
  logic [31:0] qm3, diff3;
  logic [17:0] r3_nxt;
  logic        r_ge;
  logic [15:0] days4_nxt;
  logic [16:0] sod4_nxt;

  // rebase to 2000
  assign t1_nxt = in_seconds - EPOCH_2000;

  // day estimate
  assign day_prod = 64'(t1_r) * 64'(DAY_RECIP);
  assign q2_nxt   = day_prod[DAY_SHIFT +: 16];

  // remainder against the estimate
  assign qm3    = 32'(q2_r) * 32'(SEC_PER_DAY);
  assign diff3  = t2_r - qm3;
  assign r3_nxt = diff3[17:0];

  // fix a one-low estimate
  assign r_ge      = r3_r >= 18'(SEC_PER_DAY);
  assign days4_nxt = q3_r + 16'(r_ge);
  assign sod4_nxt  = r_ge ? 17'(r3_r - 18'(SEC_PER_DAY)) : r3_r[16:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[3:1], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    t1_r    <= t1_nxt;
    t2_r    <= t1_r;
    q2_r    <= q2_nxt;
    q3_r    <= q2_r;
    r3_r    <= r3_nxt;
    days4_r <= days4_nxt;
    sod4_r  <= sod4_nxt;
  end

  assign day_o.valid = v_r[4];
  assign day_o.days  = days4_r;
  assign day_o.sod   = sod4_r;

endmodule

// ===== rtl/core/u2cal_tod_split.sv =====
module u2cal_tod_split (
  input  logic                 clk,
  input  logic                 rst_n,
  input  u2cal_pkg::day_word_t day_i,
  output u2cal_pkg::tod_word_t tod_o
);
  import u2cal_pkg::*;

  logic [10:5] v_r;
  logic [16:0] sod5_r;
  logic [4:0]  hest5_r, hest6_r, hour7_r, hour8_r, hour9_r, hour10_r;
  logic [12:0] rh6_r;
  logic [11:0] rs7_r, rs8_r;
  logic [5:0]  min8_r, min9_r, min10_r;
  logic [5:0]  sec9_r, sec10_r;

  logic [34:0] hour_prod;
  logic [4:0]  hest5_nxt;
  logic [16:0] hm6, diff6;
  logic [12:0] rh6_nxt;
  logic        h_ge;
  logic [4:0]  hour7_nxt;
  logic [11:0] rs7_nxt;
  logic [24:0] min_prod;
  logic [5:0]  min8_nxt;
  logic [11:0] sm9, diff9;
  logic [5:0]  sec9_nxt;

  // hour estimate
  assign hour_prod = 35'(day_i.sod) * 35'(HOUR_RECIP);
  assign hest5_nxt = hour_prod[HOUR_SHIFT +: 5];

  assign hm6     = 17'(hest5_r) * 17'(SEC_PER_HOUR);
  assign diff6   = sod5_r - hm6;
  assign rh6_nxt = diff6[12:0];

  assign h_ge      = rh6_r >= 13'(SEC_PER_HOUR);
  assign hour7_nxt = hest6_r + 5'(h_ge);
  assign rs7_nxt   = h_ge ? 12'(rh6_r - 13'(SEC_PER_HOUR)) : rh6_r[11:0];

  // exact minute for seconds of hour
  assign min_prod = 25'(rs7_r) * 25'(MIN_RECIP);
  assign min8_nxt = min_prod[MIN_SHIFT +: 6];

  assign sm9      = 12'(min8_r) * 12'(SEC_PER_MIN);
  assign diff9    = rs8_r - sm9;
  assign sec9_nxt = diff9[5:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[9:5], day_i.valid};
    end
  end

  always_ff @(posedge clk) begin
    sod5_r   <= day_i.sod;
    hest5_r  <= hest5_nxt;
    hest6_r  <= hest5_r;
    rh6_r    <= rh6_nxt;
    hour7_r  <= hour7_nxt;
    rs7_r    <= rs7_nxt;
    hour8_r  <= hour7_r;
    rs8_r    <= rs7_r;
    min8_r   <= min8_nxt;
    hour9_r  <= hour8_r;
    min9_r   <= min8_r;
    sec9_r   <= sec9_nxt;
    // alignment stage with the date path
    hour10_r <= hour9_r;
    min10_r  <= min9_r;
    sec10_r  <= sec9_r;
  end

  assign tod_o.valid  = v_r[10];
  assign tod_o.hour   = hour10_r;
  assign tod_o.minute = min10_r;
  assign tod_o.second = sec10_r;

endmodule

// ===== rtl/core/u2cal_date_split.sv =====
module u2cal_date_split (
  input  logic                  clk,
  input  logic                  rst_n,
  input  u2cal_pkg::day_word_t  day_i,
  output u2cal_pkg::date_word_t date_o
);
  import u2cal_pkg::*;

  logic [10:5] v_r;
  logic [15:0] days5_r;
  logic [5:0]  q5_r, q6_r, quad7_r;
  logic [11:0] rem6_r;
  logic [10:0] rem7_r;
  logic        leap8_r, leap9_r;
  logic [8:0]  doy8_r, doy9_r;
  logic [7:0]  year8_r, year9_r, year10_r;
  logic [3:0]  mon9_r, month10_r;
  logic [4:0]  day10_r;

  logic [32:0] quad_prod;
  logic [5:0]  q5_nxt;
  logic [15:0] qm6, diff6;
  logic [11:0] rem6_nxt;
  logic        q_ge;
  logic [5:0]  quad7_nxt;
  logic [10:0] rem7_nxt;
  logic        leap8_nxt;
  logic [1:0]  yi8;
  logic [8:0]  doy8_nxt;
  logic [7:0]  year8_nxt;
  logic [3:0]  mon9_nxt;
  logic [8:0]  dm10;
  logic [4:0]  day10_nxt;

  // four-year block estimate
  assign quad_prod = 33'(day_i.days) * 33'(QUAD_RECIP);
  assign q5_nxt    = quad_prod[QUAD_SHIFT +: 6];

  assign qm6      = 16'(q5_r) * 16'(DAYS_PER_QUAD);
  assign diff6    = days5_r - qm6;
  assign rem6_nxt = diff6[11:0];

  assign q_ge      = rem6_r >= 12'(DAYS_PER_QUAD);
  assign quad7_nxt = q6_r + 6'(q_ge);
  assign rem7_nxt  = q_ge ? 11'(rem6_r - 12'(DAYS_PER_QUAD)) : rem6_r[10:0];

  // year inside the block, first one leap
  always_comb begin
    if (rem7_r < 11'(YEAR1_START)) begin
      leap8_nxt = 1'b1;
      yi8       = 2'd0;
      doy8_nxt  = rem7_r[8:0];
    end else if (rem7_r < 11'(YEAR2_START)) begin
      leap8_nxt = 1'b0;
      yi8       = 2'd1;
      doy8_nxt  = 9'(rem7_r - 11'(YEAR1_START));
    end else if (rem7_r < 11'(YEAR3_START)) begin
      leap8_nxt = 1'b0;
      yi8       = 2'd2;
      doy8_nxt  = 9'(rem7_r - 11'(YEAR2_START));
    end else begin
      leap8_nxt = 1'b0;
      yi8       = 2'd3;
      doy8_nxt  = 9'(rem7_r - 11'(YEAR3_START));
    end
  end

  assign year8_nxt = 8'({quad7_r, 2'b00}) + 8'(yi8);

  // month index: count of month starts already passed
  always_comb begin
    mon9_nxt = '0;
    for (int m = 1; m < 12; m++) begin
      mon9_nxt = mon9_nxt + 4'(doy8_r >= month_first_day(4'(m), leap8_r));
    end
  end

  assign dm10      = doy9_r - month_first_day(mon9_r, leap9_r);
  assign day10_nxt = 5'(dm10) + 5'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[9:5], day_i.valid};
    end
  end

  always_ff @(posedge clk) begin
    days5_r   <= day_i.days;
    q5_r      <= q5_nxt;
    q6_r      <= q5_r;
    rem6_r    <= rem6_nxt;
    quad7_r   <= quad7_nxt;
    rem7_r    <= rem7_nxt;
    leap8_r   <= leap8_nxt;
    doy8_r    <= doy8_nxt;
    year8_r   <= year8_nxt;
    leap9_r   <= leap8_r;
    doy9_r    <= doy8_r;
    year9_r   <= year8_r;
    mon9_r    <= mon9_nxt;
    year10_r  <= year9_r;
    month10_r <= mon9_r + 4'd1;
    day10_r   <= day10_nxt;
  end

  assign date_o.valid = v_r[10];
  assign date_o.year  = year10_r;
  assign date_o.month = month10_r;
  assign date_o.day   = day10_r;

endmodule

// ===== rtl/core/unix_time_to_calendar_core.sv =====
// unix seconds to calendar date and time of day, years counted from 2000
//
// input: pulse start with in_unix_seconds; the word is taken at any rising
// edge with start high and busy low. busy never rises, so a new word may be
// sent on every clock.
// output: out_valid is high for exactly one cycle per input word and marks
// second, minute, hour, day, month and year offset on the out_ ports.
// the receiver cannot stall; results must be taken in the strobe cycle.
// throughput one word per clock, set by the ten-stage pipeline (rebase,
// day reciprocal, two remainder/correct stages, then parallel date and
// time-of-day lanes of six stages each).
// leap rule: every fourth year from 2000, no century exception.
// inputs before 2000 wrap modulo 2^32 into years 2106 to 2136.
// reset: synchronous, active low; flushes every word in flight, none of them
// gives a strobe. there is no other state.
`include "unix_time_to_calendar_core_macros.svh"

module unix_time_to_calendar_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] in_unix_seconds,
  output logic        out_valid,
  output logic [5:0]  out_second_of_minute,
  output logic [5:0]  out_minute_of_hour,
  output logic [4:0]  out_hour_of_day,
  output logic [4:0]  out_day_of_month,
  output logic [3:0]  out_month_number,
  output logic [7:0]  out_year_offset
);
  import u2cal_pkg::*;

  day_word_t  day_w;
  tod_word_t  tod_w;
  date_word_t date_w;
  logic       in_accept;

  // fully pipelined, always ready
  assign busy      = 1'b0;
  assign in_accept = start && !busy;

  // stages 1-4: rebase and split into days and seconds of day
  u2cal_day_split u_day (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_accept),
    .in_seconds (in_unix_seconds),
    .day_o      (day_w)
  );

  // stages 5-10: hour, minute, second
  u2cal_tod_split u_tod (
    .clk   (clk),
    .rst_n (rst_n),
    .day_i (day_w),
    .tod_o (tod_w)
  );

  // stages 5-10: year, month, day of month
  u2cal_date_split u_date (
    .clk    (clk),
    .rst_n  (rst_n),
    .day_i  (day_w),
    .date_o (date_w)
  );

  // both lanes carry the same valid pattern
  assign out_valid            = date_w.valid;
  assign out_second_of_minute = tod_w.second;
  assign out_minute_of_hour   = tod_w.minute;
  assign out_hour_of_day      = tod_w.hour;
  assign out_day_of_month     = date_w.day;
  assign out_month_number     = date_w.month;
  assign out_year_offset      = date_w.year;

  // lanes stay in step
  `U2CAL_ASSERT(a_lane_sync, clk, rst_n, 1'b1, tod_w.valid == date_w.valid)
  // every accepted word gives a strobe after the pipeline latency
  `U2CAL_ASSERT_DLY(a_word_out, clk, rst_n, in_accept, PIPE_LATENCY, out_valid)
  // no strobe without an accepted word
  `U2CAL_ASSERT(a_no_ghost, clk, rst_n, out_valid, $past(in_accept, PIPE_LATENCY))
  // fields in range
  `U2CAL_ASSERT(a_ranges, clk, rst_n, out_valid, (out_second_of_minute < 6'd60) && (out_minute_of_hour < 6'd60) && (out_hour_of_day < 5'd24) && (out_month_number >= 4'd1) && (out_month_number <= 4'd12) && (out_day_of_month >= 5'd1))

endmodule
